FILE: sv/exact_odd_divide_mod_pow2_core_macros.svh
// ----------------------------------------------------------------------------
// exact odd divide assertion macros
// shared concurrent assertion forms for the exact odd divide core
// ----------------------------------------------------------------------------
`ifndef EXACT_ODD_DIVIDE_MOD_POW2_CORE_MACROS_SVH
`define EXACT_ODD_DIVIDE_MOD_POW2_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define EODM_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eodm assertion failed");

// next-cycle implication, checked out of reset
`define EODM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eodm assertion failed");

`endif

FILE: sv/eodm_pkg.sv
// ----------------------------------------------------------------------------
// eodm_pkg
// width codes, control group and masks for the exact odd divide core
// ----------------------------------------------------------------------------
package eodm_pkg;

    localparam int unsigned FIELD_W = 64;

    typedef enum logic [1:0] {
        MODE_W8  = 2'd0,
        MODE_W16 = 2'd1,
        MODE_W32 = 2'd2,
        MODE_W64 = 2'd3
    } eodm_mode_t;

    typedef struct packed {
        logic       valid;
        logic       even;
        eodm_mode_t mode;
    } eodm_ctrl_t;

    function automatic logic [FIELD_W-1:0] mode_mask(eodm_mode_t mode);
        logic [FIELD_W-1:0] m;
        unique case (mode)
            MODE_W8:  m = 64'h0000_0000_0000_00ff;
            MODE_W16: m = 64'h0000_0000_0000_ffff;
            MODE_W32: m = 64'h0000_0000_ffff_ffff;
            MODE_W64: m = 64'hffff_ffff_ffff_ffff;
            default:  m = 64'hffff_ffff_ffff_ffff;
        endcase
        return m;
    endfunction

endpackage

FILE: sv/eodm_stage.sv
// ----------------------------------------------------------------------------
// eodm_stage
// one quotient bit: conditional add of the shifted correction term
// ----------------------------------------------------------------------------
`include "exact_odd_divide_mod_pow2_core_macros.svh"

module eodm_stage #(
    parameter int unsigned MAX_WIDTH = 64,
    parameter int unsigned BIT       = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  eodm_pkg::eodm_ctrl_t    ctrl_in,
    input  logic [MAX_WIDTH-1:0]    acc_in,
    input  logic [MAX_WIDTH-1:0]    term_in,
    output eodm_pkg::eodm_ctrl_t    ctrl_out,
    output logic [MAX_WIDTH-1:0]    acc_out,
    output logic [MAX_WIDTH-1:0]    term_out
);

    eodm_pkg::eodm_ctrl_t   ctrl_reg;
    logic [MAX_WIDTH-1:0]   acc_reg;
    logic [MAX_WIDTH-1:0]   term_reg;
    logic [MAX_WIDTH-1:0]   acc_next;
    logic [MAX_WIDTH-1:0]   term_next;

    always_comb
    begin
        acc_next  = acc_in[BIT] ? (acc_in + term_in) : acc_in;
        term_next = term_in << 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg  <= acc_next;
            term_reg <= term_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign acc_out  = acc_reg;
    assign term_out = term_reg;

    // with an odd divisor the term is even at this bit, so the bit is final
    `EODM_ASSERT_NEXT(a_bit_settled, clk, rst_n,
        en && ctrl_in.valid && !ctrl_in.even && !term_in[BIT],
        acc_reg[BIT] == $past(acc_in[BIT]))

endmodule

FILE: sv/exact_odd_divide_mod_pow2_core.sv
// ----------------------------------------------------------------------------
// exact_odd_divide_mod_pow2_core
// exact division by an odd divisor modulo 2^w, one quotient bit per stage
// ----------------------------------------------------------------------------
// channel | handshake          | fields
// in      | in_valid, in_stall | mode, dividend, divisor
// out     | out_valid, out_stall | quotient, even_divisor
//
// one item per cycle while the pipeline moves; registers in order: entry, one stage per
// quotient bit, output register; the bit stages set the depth
// reset clears the valid bits and the control fields only, no clearing pass
// the whole pipeline moves together; it holds only while the output item
// is stalled and the last bit stage holds an item
// ----------------------------------------------------------------------------
`include "exact_odd_divide_mod_pow2_core_macros.svh"

module exact_odd_divide_mod_pow2_core #(
    parameter int unsigned MAX_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] quotient,
    output logic        even_divisor
);

    eodm_pkg::eodm_ctrl_t   ctrl_s [0:MAX_WIDTH];
    logic [MAX_WIDTH-1:0]   acc_s  [0:MAX_WIDTH];
    logic [MAX_WIDTH-1:0]   term_s [0:MAX_WIDTH];

    eodm_pkg::eodm_ctrl_t   entry_ctrl_next;
    logic                   en;
    logic                   out_load;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [63:0]            quotient_reg;
    logic [63:0]            quotient_next;
    logic                   even_reg;
    logic [63:0]            mode_bits;
    logic [MAX_WIDTH-1:0]   last_mask;

    assign en       = !out_valid_reg || !out_stall || !ctrl_s[MAX_WIDTH].valid;
    assign out_load = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // entry register: operands cut to the datapath width, term = 1 - divisor
    always_comb
    begin
        entry_ctrl_next.valid = in_valid;
        entry_ctrl_next.even  = !divisor[0];
        entry_ctrl_next.mode  = eodm_pkg::eodm_mode_t'(mode);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_s[0] <= '0;
        end
        else if (en)
        begin
            ctrl_s[0] <= entry_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_s[0]  <= dividend[MAX_WIDTH-1:0];
            term_s[0] <= MAX_WIDTH'(1) - divisor[MAX_WIDTH-1:0];
        end
    end

    for (genvar i = 0; i < MAX_WIDTH; i++)
    begin : g_stage
        eodm_stage #(
            .MAX_WIDTH (MAX_WIDTH),
            .BIT       (i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctrl_in  (ctrl_s[i]),
            .acc_in   (acc_s[i]),
            .term_in  (term_s[i]),
            .ctrl_out (ctrl_s[i+1]),
            .acc_out  (acc_s[i+1]),
            .term_out (term_s[i+1])
        );
    end

    // output register: cut to the selected width, zero for an even divisor
    always_comb
    begin
        mode_bits      = eodm_pkg::mode_mask(ctrl_s[MAX_WIDTH].mode);
        last_mask      = mode_bits[MAX_WIDTH-1:0];
        out_valid_next = ctrl_s[MAX_WIDTH].valid;
        quotient_next  = '0;
        if (!ctrl_s[MAX_WIDTH].even)
        begin
            quotient_next = 64'(acc_s[MAX_WIDTH] & last_mask);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            quotient_reg <= quotient_next;
            even_reg     <= ctrl_s[MAX_WIDTH].even;
        end
    end

    assign out_valid    = out_valid_reg;
    assign quotient     = quotient_reg;
    assign even_divisor = even_reg;

    `EODM_ASSERT_NOW(a_even_gives_zero, clk, rst_n,
        out_valid_reg && even_reg, quotient_reg == 64'd0)
    `EODM_ASSERT_NEXT(a_last_item_held, clk, rst_n,
        out_valid_reg && out_stall && ctrl_s[MAX_WIDTH].valid,
        ctrl_s[MAX_WIDTH].valid && $stable(acc_s[MAX_WIDTH]))
    `EODM_ASSERT_NOW(a_in_stall_only_when_full, clk, rst_n,
        in_stall, out_valid_reg && ctrl_s[MAX_WIDTH].valid)

endmodule
